// ----- rtl/core/savs_pkg.sv -----
// Shared constants, types and a rounding helper for the stereo allpass shaper.
package savs_pkg;

	localparam int DELAY_SLOTS = 2048;
	localparam int ADDR_W      = $clog2(DELAY_SLOTS);
	localparam int MAX_DELAY   = 1501;
	localparam int SAMPLE_BITS = 24;
	localparam int QBITS       = 28;
	localparam int PORT_SHIFT  = QBITS - (SAMPLE_BITS - 1);
	localparam int MW          = 36;
	localparam int PW          = 2 * MW;
	localparam int WORD_W      = 32;
	localparam int PADDR_W     = 3;

	// golden ratio conjugate in Q.28
	localparam logic signed [MW-1:0] GOLD = MW'(165902236);
	// reciprocals for exact floor division: x/6, x/120, x/3, x/45
	localparam logic signed [MW-1:0] RECIP6   = MW'(11184811);
	localparam logic signed [MW-1:0] RECIP120 = MW'(8947849);
	localparam logic signed [MW-1:0] RECIP3   = MW'(64'd5726623062);
	localparam logic signed [MW-1:0] RECIP45  = MW'(64'd3054198967);
	localparam int SH6   = 26;
	localparam int SH120 = 30;
	localparam int SH3   = 34;
	localparam int SH45  = 37;

	localparam logic REG_NUDGE = 1'b0;
	localparam logic REG_WET   = 1'b1;

	typedef struct packed {
		logic [15:0] nudge;
		logic [16:0] wet;
	} savs_cfg_t;

	// divide by 2^k, round to nearest, ties away from zero
	function automatic logic signed [PW-1:0] rnd_pow2(input logic signed [PW-1:0] p,
		input int k);
		logic [PW-1:0] m;
		logic [PW-1:0] r;
		m = p[PW-1] ? PW'(-p) : PW'(p);
		r = (m + (PW'(1) << (k - 1))) >> k;
		return p[PW-1] ? -$signed(r) : $signed(r);
	endfunction

endpackage

// ----- rtl/core/stereo_variable_allpass_shaper_unit.sv -----
// Top level: sequencer around one shared multiplier and the delay-line RAM.
// Path from input transaction to output valid: target, glide (skipped when the length already
// matches), address, per channel the multiplier steps (dry blend skipped when fully wet), write-back.
// One pair at a time. The next input is taken the cycle after write-back; output is held in its own register.
// Throughput is set by the shared multiplier; a new pair is taken only after the last is written back.
// Reset: asynchronous; afterwards a pass over every slot zeroes the delay RAM, tready low meanwhile.
module stereo_variable_allpass_shaper_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [savs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [47:0]                   s_axis_tdata,  // left_sample, right_sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [47:0]                   m_axis_tdata   // left_out, right_out
);
	import savs_pkg::*;

	typedef enum logic [5:0] {
		ST_CLR, ST_IDLE, ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
		ST_G0, ST_G1, ST_G2, ST_A0, ST_A1,
		ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7,
		ST_C8, ST_C9, ST_C10, ST_C11, ST_C12, ST_C13, ST_C14, ST_C15, ST_W
	} state_t;

	savs_cfg_t cfg;
	state_t    state_q;

	logic                          ch_q;
	logic signed [SAMPLE_BITS-1:0] in_l_q, in_r_q;
	logic [ADDR_W-1:0]             clr_q, tgt_q, len_q, nb_q, wp_q, rd_q;
	logic                          len_valid_q;
	logic [23:0]                   yh_q;
	logic signed [PW-1:0]          acc_q;
	logic [63:0]                   zero_q, line_q;
	logic signed [MW-1:0]          av_q, x2_q, x3_q, x5_q, d1_q, s_q, u_q, u4_q, mix_q;
	logic signed [WORD_W-1:0]      t_q [2];
	logic signed [SAMPLE_BITS-1:0] res_q [2];
	logic                          out_valid_q;
	logic [47:0]                   out_q;

	logic signed [MW-1:0]    ma, mb;
	logic signed [PW-1:0]    mp, r28;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_wa, ram_ra;
	logic [63:0]             ram_wd, ram_rd;

	logic signed [SAMPLE_BITS-1:0] smp;
	logic signed [28:0]            dry, qv;
	logic signed [MW-1:0]          qa;
	logic signed [WORD_W-1:0]      line_h;
	logic [ADDR_W-1:0]             rd_c;

	savs_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	savs_mul u_mul (.clk, .a(ma), .b(mb), .p_q(mp));

	savs_ram #(.WIDTH(64), .DEPTH(DELAY_SLOTS)) u_ram (
		.clk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(ram_rd)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	assign smp    = ch_q ? in_r_q : in_l_q;
	assign dry    = $signed({smp, {PORT_SHIFT{1'b0}}});
	assign qv     = dry >>> 2;
	assign qa     = qv[28] ? MW'(-qv) : MW'(qv);
	assign r28    = rnd_pow2(mp, QBITS);
	assign line_h = ch_q ? $signed(line_q[63:32]) : $signed(line_q[31:0]);
	assign rd_c   = (wp_q == '0 || (wp_q - 1'b1) > len_q) ? len_q : wp_q - 1'b1;

	// datapath and combinational operands
	logic signed [32:0]       avg_l, avg_r;
	logic signed [MW-1:0]     s_mag, c_v, u_adj, u4_v, ac_v, u_v, nxv;
	logic signed [MW+1:0]     t_full;
	logic signed [WORD_W-1:0] t_v;
	logic signed [PW-1:0]     tg_full, pr;
	logic [ADDR_W-1:0]        len_s;
	logic signed [ADDR_W+1:0] diff;

	always_comb begin
		avg_l   = $signed({zero_q[31], zero_q[31:0]}) + $signed({ram_rd[31], ram_rd[31:0]});
		avg_r   = $signed({zero_q[63], zero_q[63:32]}) + $signed({ram_rd[63], ram_rd[63:32]});
		avg_l   = (avg_l + 33'(avg_l[32])) >>> 1;
		avg_r   = (avg_r + 33'(avg_r[32])) >>> 1;
		s_mag   = av_q - d1_q + MW'(mp >>> SH120);
		t_full  = (MW+2)'(s_q) - (MW+2)'(r28);
		if (t_full > (MW+2)'(2147483647)) begin
			t_v = 32'sh7FFFFFFF;
		end else if (t_full < -(MW+2)'(64'sd2147483648)) begin
			t_v = 32'sh80000000;
		end else begin
			t_v = t_full[WORD_W-1:0];
		end
		nxv     = (wp_q == rd_q) ? MW'(t_q[ch_q]) : MW'(line_h);
		u_v     = MW'(r28) + nxv;
		ac_v    = u_v[MW-1] ? -u_v : u_v;
		if (ac_v > MW'(64'd536870912)) begin
			ac_v = MW'(64'd536870912);
		end
		c_v     = (x2_q >>> 1) - d1_q + MW'(mp >>> SH45);
		u_adj   = (u_q > 0) ? u_q - c_v : u_q + c_v;
		u4_v    = u_adj <<< 2;
		tg_full = (mp + (acc_q >>> 24)) >>> 24;
		diff    = $signed({2'b00, len_q}) - $signed({2'b00, tgt_q});
		if (diff < 0) begin
			diff = -diff;
		end
		len_s   = (!len_valid_q || diff > (ADDR_W+2)'(MAX_DELAY - 1)) ? tgt_q : len_q;
		pr      = rnd_pow2(PW'(mix_q), PORT_SHIFT);
	end

	always_comb begin
		ma     = '0;
		mb     = '0;
		ram_we = 1'b0;
		ram_wa = len_q;
		ram_wd = '0;
		ram_ra = '0;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
			end
			ST_T0: begin
				ma = MW'(cfg.nudge);
				mb = MW'(cfg.nudge);
			end
			ST_T1: begin
				ma = MW'(mp[31:0]);
				mb = MW'(cfg.nudge);
			end
			ST_T2: begin
				ma = MW'(mp[23:0]);
				mb = MW'(MAX_DELAY);
			end
			ST_T3: begin
				ma = MW'(yh_q);
				mb = MW'(MAX_DELAY);
			end
			ST_G1:  ram_ra = nb_q;
			ST_G2: begin
				ram_we = 1'b1;
				ram_wa = len_q;
				ram_wd = {avg_r[31:0], avg_l[31:0]};
			end
			ST_A0:  ram_ra = rd_c;
			ST_C0: begin
				ma = qa;
				mb = qa;
			end
			ST_C1: begin
				ma = MW'(r28);
				mb = av_q;
			end
			ST_C2: begin
				ma = MW'(r28);
				mb = x2_q;
			end
			ST_C3: begin
				ma = x3_q;
				mb = RECIP6;
			end
			ST_C4: begin
				ma = x5_q;
				mb = RECIP120;
			end
			ST_C5: begin
				ma = MW'(line_h);
				mb = GOLD;
			end
			ST_C6: begin
				ma = MW'(t_v);
				mb = GOLD;
			end
			ST_C7: begin
				ma = ac_v;
				mb = ac_v;
			end
			ST_C8: begin
				ma = MW'(r28);
				mb = MW'(r28);
			end
			ST_C9: begin
				ma = MW'(r28);
				mb = x2_q;
			end
			ST_C10: begin
				ma = x3_q >>> 3;
				mb = RECIP3;
			end
			ST_C11: begin
				ma = x5_q >>> 4;
				mb = RECIP45;
			end
			ST_C12: begin
				ma = MW'(dry);
				mb = MW'(18'd65536 - {1'b0, cfg.wet});
			end
			ST_C13: begin
				ma = u4_q;
				mb = MW'(cfg.wet);
			end
			ST_W: begin
				ram_we = !out_valid_q || m_axis_tready;
				ram_wa = wp_q;
				ram_wd = {t_q[1], t_q[0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			ch_q        <= 1'b0;
			len_q       <= '0;
			wp_q        <= ADDR_W'(1);
			len_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// write-back reloads the output register itself
			if (m_axis_tvalid && m_axis_tready && state_q != ST_W) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						in_l_q  <= s_axis_tdata[23:0];
						in_r_q  <= s_axis_tdata[47:24];
						state_q <= ST_T0;
					end
				end
				ST_T0: state_q <= ST_T1;
				ST_T1: state_q <= ST_T2;
				ST_T2: begin
					yh_q    <= mp[47:24];
					state_q <= ST_T3;
				end
				ST_T3: begin
					acc_q   <= mp;
					state_q <= ST_T4;
				end
				ST_T4: begin
					tgt_q   <= (tg_full > PW'(DELAY_SLOTS - 1)) ? ADDR_W'(DELAY_SLOTS - 1)
						: tg_full[ADDR_W-1:0];
					state_q <= ST_T5;
				end
				ST_T5: begin
					len_valid_q <= 1'b1;
					if (len_s < tgt_q) begin
						len_q   <= len_s + 1'b1;
						nb_q    <= len_s;
						state_q <= ST_G0;
					end else if (len_s > tgt_q) begin
						len_q   <= len_s - 1'b1;
						nb_q    <= len_s - 1'b1;
						state_q <= ST_G0;
					end else begin
						len_q   <= len_s;
						state_q <= ST_A0;
					end
				end
				ST_G0: state_q <= ST_G1;
				ST_G1: begin
					zero_q  <= ram_rd;
					state_q <= ST_G2;
				end
				ST_G2: state_q <= ST_A0;
				ST_A0: begin
					rd_q    <= rd_c;
					state_q <= ST_A1;
				end
				ST_A1: begin
					line_q  <= ram_rd;
					ch_q    <= 1'b0;
					state_q <= ST_C0;
				end
				ST_C0: begin
					av_q    <= qa;
					state_q <= ST_C1;
				end
				ST_C1: begin
					x2_q    <= MW'(r28);
					state_q <= ST_C2;
				end
				ST_C2: begin
					x3_q    <= MW'(r28);
					state_q <= ST_C3;
				end
				ST_C3: begin
					x5_q    <= MW'(r28);
					state_q <= ST_C4;
				end
				ST_C4: begin
					d1_q    <= MW'(mp >>> SH6);
					state_q <= ST_C5;
				end
				ST_C5: begin
					s_q     <= (smp > 0) ? s_mag : -s_mag;
					state_q <= ST_C6;
				end
				ST_C6: begin
					t_q[ch_q] <= t_v;
					state_q   <= ST_C7;
				end
				ST_C7: begin
					u_q     <= u_v;
					state_q <= ST_C8;
				end
				ST_C8: begin
					x2_q    <= MW'(r28);
					state_q <= ST_C9;
				end
				ST_C9: begin
					x3_q    <= MW'(r28);
					state_q <= ST_C10;
				end
				ST_C10: begin
					// sixth power, scaled down in the next step
					x5_q    <= MW'(r28);
					state_q <= ST_C11;
				end
				ST_C11: begin
					d1_q    <= MW'(mp >>> SH3);
					state_q <= ST_C12;
				end
				ST_C12: begin
					u4_q  <= u4_v;
					mix_q <= u4_v;
					// fully wet skips the dry blend
					state_q <= cfg.wet[16] ? ST_C15 : ST_C13;
				end
				ST_C13: begin
					acc_q   <= mp;
					state_q <= ST_C14;
				end
				ST_C14: begin
					mix_q   <= MW'(rnd_pow2(acc_q + mp, 16));
					state_q <= ST_C15;
				end
				ST_C15: begin
					if (pr > PW'(2 ** (SAMPLE_BITS - 1) - 1)) begin
						res_q[ch_q] <= SAMPLE_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
					end else if (pr < -PW'(2 ** (SAMPLE_BITS - 1))) begin
						res_q[ch_q] <= SAMPLE_BITS'(-(2 ** (SAMPLE_BITS - 1)));
					end else begin
						res_q[ch_q] <= pr[SAMPLE_BITS-1:0];
					end
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= ST_C0;
					end else begin
						state_q <= ST_W;
					end
				end
				ST_W: begin
					if (!out_valid_q || m_axis_tready) begin
						out_q       <= {res_q[1], res_q[0]};
						out_valid_q <= 1'b1;
						wp_q        <= rd_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_idle_no_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("delay RAM written while idle");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !s_axis_tready)
		else $error("input taken during RAM clear");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_valid_q |-> len_q <= ADDR_W'(MAX_DELAY - 1))
		else $error("delay length beyond maximum");

	a_pos_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && len_valid_q) |-> wp_q <= len_q)
		else $error("write position beyond delay length");
endmodule

// ----- rtl/core/savs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module savs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/savs_mul.sv -----
// Shared signed multiplier with registered product.
module savs_mul (
	input  logic                            clk,
	input  logic signed [savs_pkg::MW-1:0]  a,
	input  logic signed [savs_pkg::MW-1:0]  b,
	output logic signed [savs_pkg::PW-1:0]  p_q
);
	import savs_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

// ----- rtl/core/savs_cfg.sv -----
// APB register file: nudge amount and wet mix.
module savs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [savs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output savs_pkg::savs_cfg_t           cfg
);
	import savs_pkg::*;

	savs_cfg_t cfg_q;
	logic      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nudge <= '0;
			cfg_q.wet   <= 17'd65536;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_NUDGE: cfg_q.nudge <= pwdata[15:0];
				REG_WET:   cfg_q.wet   <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NUDGE: prdata = 32'(cfg_q.nudge);
			REG_WET:   prdata = 32'(cfg_q.wet);
			default:   prdata = '0;
		endcase
	end
endmodule
